FILE: hw/rtl/morse_element_timer_top_defines.svh
// Assertion macros for the Morse element timer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MORSE_ELEMENT_TIMER_TOP_DEFINES_SVH
`define MORSE_ELEMENT_TIMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check with reset disable
`define MET_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds during reset
`define MET_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MET_ASSERT_RST(label, clk, rstn, prop, msg)
`define MET_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/met_pkg.sv
// Shared types, constants and helpers for the Morse element timer.
// No dependencies; used by the channel interfaces and the top level.
package met_pkg;

  localparam int UNIT_W    = 16;
  localparam int PATTERN_W = 8;
  localparam int LEN_W     = 4;
  localparam int ELAPSED_W = 16;
  localparam int TIMER_W   = 20;

  localparam logic [UNIT_W-1:0]  UNIT_TICKS_RST = 16'd1200;
  localparam logic [TIMER_W-1:0] TIMER_MAX      = 20'hFFFFF;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // saturating timer add
  function automatic logic [TIMER_W-1:0] sat_add(
    input logic [TIMER_W-1:0]   a,
    input logic [ELAPSED_W-1:0] b
  );
    logic [TIMER_W:0] s;
    s = {1'b0, a} + (TIMER_W+1)'(b);
    return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/met_if.sv
// Valid/ready channel interfaces of the Morse element timer.
// Depends on met_pkg for field widths and the op type.
interface met_in_if;
  logic                           valid;
  logic                           ready;
  met_pkg::op_t                   op;
  logic [met_pkg::PATTERN_W-1:0]  pattern;
  logic [met_pkg::LEN_W-1:0]      pattern_len;
  logic [met_pkg::ELAPSED_W-1:0]  elapsed;
  modport source (output valid, op, pattern, pattern_len, elapsed, input ready);
  modport sink   (input valid, op, pattern, pattern_len, elapsed, output ready);
endinterface

interface met_out_if;
  logic valid;
  logic ready;
  logic tone_on;
  logic char_done;
  logic busy_res;
  modport source (output valid, tone_on, char_done, busy_res, input ready);
  modport sink   (input valid, tone_on, char_done, busy_res, output ready);
endinterface

interface met_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [met_pkg::UNIT_W-1:0] unit_ticks;
  modport source (output valid, unit_ticks, input ready);
  modport sink   (input valid, unit_ticks, output ready);
endinterface

FILE: hw/rtl/morse_element_timer_top.sv
// Morse element timer: keys the dit/dash elements of one character.
// Depends on met_pkg, the channel interfaces in met_if.sv and the assertion header.
//
// Usage: write unit_ticks (length of one dit, reset 1200) on cfg_ch while idle.
// A start word (op = start) loads the dash pattern (bit 0 plays first) and the
// element count, clamped to MAX_ELEMENTS; the running timer is kept. Each tick
// word adds its elapsed count to a 20-bit saturating timer. A dit sounds for one
// unit, a dash for three, then a one-unit gap follows, checked in the same tick.
// The last element ends the character at once with char_done, no trailing gap.
// Every input word gives exactly one result word. Throughput is one word per
// clock: the element timing is a single add and compare pass from the input
// port into the result register, and the next word is taken while a result
// waits, as long as the result register is empty or being drained that cycle.
// out_ch.valid is registered and rises in the cycle after acceptance.
`include "morse_element_timer_top_defines.svh"

module morse_element_timer_top #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  met_in_if.sink     in_ch,
  met_out_if.source  out_ch,
  met_cfg_if.sink    cfg_ch
);

  localparam int IW  = $clog2(MAX_ELEMENTS);      // element index width
  localparam int LW  = $clog2(MAX_ELEMENTS + 1);  // stored length width
  localparam int PIW = $clog2(met_pkg::PATTERN_W);
  localparam int TW  = met_pkg::TIMER_W;

  // character state
  logic                          playing_r, playing_nxt;
  logic                          in_gap_r, in_gap_nxt;
  logic [IW-1:0]                 element_index_r, element_index_nxt;
  logic [TW-1:0]                 elapsed_total_r, elapsed_total_nxt;
  logic [met_pkg::PATTERN_W-1:0] stored_pattern_r, stored_pattern_nxt;
  logic [LW-1:0]                 stored_length_r, stored_length_nxt;
  logic [met_pkg::UNIT_W-1:0]    unit_ticks_r;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic tone_on_r, tone_on_nxt;
  logic char_done_r, char_done_nxt;
  logic busy_res_r;

  logic          in_acc;
  logic [TW-1:0] unit_w;
  logic [TW-1:0] limit;
  logic          is_dash;
  logic [TW-1:0] tone_sum;
  logic [TW-1:0] gap_base;
  logic [TW-1:0] gap_sum;
  logic          tone_hit;
  logic          gap_now;
  logic [LW:0]   idx_p1;
  logic          last_elem;

  assign cfg_ch.ready = 1'b1;
  // take a word when the result slot is free or draining this cycle
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tone_on   = tone_on_r;
  assign out_ch.char_done = char_done_r;
  assign out_ch.busy_res  = busy_res_r;

  // element length: one unit for a dit, three for a dash (fits in 18 bits)
  assign unit_w  = TW'(unit_ticks_r);
  assign is_dash = (32'(element_index_r) < met_pkg::PATTERN_W) &&
                   stored_pattern_r[element_index_r[PIW-1:0]];
  assign limit   = is_dash ? (unit_w + (unit_w << 1)) : unit_w;

  assign tone_sum = met_pkg::sat_add(elapsed_total_r, in_ch.elapsed);
  assign tone_hit = !in_gap_r && (tone_sum >= limit);
  // a gap that opens this tick starts from a cleared timer
  assign gap_now  = in_gap_r || tone_hit;
  assign gap_base = in_gap_r ? elapsed_total_r : '0;
  assign gap_sum  = met_pkg::sat_add(gap_base, in_ch.elapsed);

  assign idx_p1    = (LW+1)'(element_index_r) + (LW+1)'(1);
  assign last_elem = idx_p1 >= (LW+1)'(stored_length_r);

  always_comb begin
    playing_nxt        = playing_r;
    in_gap_nxt         = in_gap_r;
    element_index_nxt  = element_index_r;
    elapsed_total_nxt  = elapsed_total_r;
    stored_pattern_nxt = stored_pattern_r;
    stored_length_nxt  = stored_length_r;
    tone_on_nxt        = 1'b0;
    char_done_nxt      = 1'b0;

    if (in_ch.op == met_pkg::OP_START) begin
      stored_pattern_nxt = in_ch.pattern;
      if (32'(in_ch.pattern_len) > MAX_ELEMENTS) begin
        stored_length_nxt = LW'(MAX_ELEMENTS);
      end else begin
        stored_length_nxt = LW'(in_ch.pattern_len);
      end
      element_index_nxt = '0;
      in_gap_nxt        = 1'b0;
      playing_nxt       = 1'b1;
    end else if (playing_r) begin
      if (stored_length_r == '0) begin
        // empty character: ends on the first tick, silent
        playing_nxt       = 1'b0;
        in_gap_nxt        = 1'b0;
        element_index_nxt = '0;
        elapsed_total_nxt = '0;
        char_done_nxt     = 1'b1;
      end else begin
        if (!in_gap_r) begin
          tone_on_nxt       = !tone_hit;
          elapsed_total_nxt = tone_sum;
        end
        if (gap_now) begin
          elapsed_total_nxt = gap_sum;
          in_gap_nxt        = 1'b1;
          if (last_elem) begin
            playing_nxt       = 1'b0;
            in_gap_nxt        = 1'b0;
            element_index_nxt = '0;
            elapsed_total_nxt = '0;
            char_done_nxt     = 1'b1;
          end else if (gap_sum >= unit_w) begin
            elapsed_total_nxt = '0;
            in_gap_nxt        = 1'b0;
            element_index_nxt = element_index_r + IW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r        <= 1'b0;
      in_gap_r         <= 1'b0;
      element_index_r  <= '0;
      elapsed_total_r  <= '0;
      stored_pattern_r <= '0;
      stored_length_r  <= LW'(1);
      unit_ticks_r     <= met_pkg::UNIT_TICKS_RST;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        unit_ticks_r <= cfg_ch.unit_ticks;
      end
      if (in_acc) begin
        playing_r        <= playing_nxt;
        in_gap_r         <= in_gap_nxt;
        element_index_r  <= element_index_nxt;
        elapsed_total_r  <= elapsed_total_nxt;
        stored_pattern_r <= stored_pattern_nxt;
        stored_length_r  <= stored_length_nxt;
      end
    end
  end

  // result payload, loaded with each accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tone_on_r   <= tone_on_nxt;
      char_done_r <= char_done_nxt;
      busy_res_r  <= playing_nxt;
    end
  end

  // idle block holds a cleared timer and no gap
  `MET_ASSERT_RST(a_idle_clear, clk, rst_n,
    !playing_r |-> (elapsed_total_r == '0) && !in_gap_r,
    "timer or gap flag set while idle")
  // index always points inside the loaded character
  `MET_ASSERT_RST(a_index_range, clk, rst_n,
    playing_r && (stored_length_r != '0) |-> (LW'(element_index_r) < stored_length_r),
    "element index beyond character length")
  // an accepted start leaves the block playing
  `MET_ASSERT_RST(a_start_plays, clk, rst_n,
    in_acc && (in_ch.op == met_pkg::OP_START) |=> playing_r && out_valid_r && busy_res_r,
    "start word did not begin a character")
  // a sounding or finishing result is consistent with the busy flag
  `MET_ASSERT_RST(a_result_flags, clk, rst_n,
    out_valid_r && (tone_on_r || char_done_r) |-> (busy_res_r == !char_done_r) &&
      !(tone_on_r && char_done_r),
    "inconsistent result flags")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for morse_element_timer_top: start and tick words in, one result out.
// Depends on met_pkg and the channel interfaces in met_if.sv; an in-bench keyer model predicts
// every result, with random idling on both channels.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNIT_W    = met_pkg::UNIT_W;
  localparam int PATTERN_W = met_pkg::PATTERN_W;
  localparam int LEN_W     = met_pkg::LEN_W;
  localparam int ELAPSED_W = met_pkg::ELAPSED_W;
  localparam int TIMER_W   = met_pkg::TIMER_W;

  localparam int MAX_ELEMENTS = 8;
  // Timeout guard against a hung run; keep a wide margin.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 1250;
  localparam int MAX_REPORTS  = 10;

  // One expected result word.
  typedef struct packed {
    logic tone_on;
    logic char_done;
    logic busy_res;
  } keying_word_t;

  logic clk;
  logic rst_n;

  met_in_if  in_ch ();
  met_out_if out_ch ();
  met_cfg_if cfg_ch ();

  morse_element_timer_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Keyer model state. Mirrors the block's registers at their own widths and is
  // advanced once per accepted input word, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [UNIT_W-1:0]    kp_unit;
  logic                 kp_playing;
  logic                 kp_gap;
  logic [2:0]           kp_index;
  logic [TIMER_W-1:0]   kp_timer;
  logic [PATTERN_W-1:0] kp_pattern;
  logic [LEN_W-1:0]     kp_length;

  keying_word_t expected_keying[$];

  int  cycles;
  int  words_sent;
  int  results_checked;
  int  mismatch_count;
  int  unit_writes;
  bit  fast_path;  // when set, neither side idles

  // Timer add that sticks at the 20-bit ceiling.
  function automatic logic [TIMER_W-1:0] timer_plus(input logic [TIMER_W-1:0] t,
                                                    input logic [ELAPSED_W-1:0] e);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + {{(TIMER_W+1-ELAPSED_W){1'b0}}, e};
    return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

  function automatic void end_character();
    kp_playing = 1'b0;
    kp_gap     = 1'b0;
    kp_index   = '0;
    kp_timer   = '0;
  endfunction

  // Advance the keyer by one word and return the result word it produces.
  function automatic keying_word_t advance_keyer(input met_pkg::op_t op,
                                                 input logic [PATTERN_W-1:0] pat,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [ELAPSED_W-1:0] el);
    keying_word_t r;
    logic [TIMER_W-1:0] limit;
    r = '0;
    if (op == met_pkg::OP_START) begin
      // restart: pattern and length reload, timer is deliberately kept
      kp_pattern = pat;
      kp_length  = (32'(len) > MAX_ELEMENTS) ? LEN_W'(MAX_ELEMENTS) : len;
      kp_index   = '0;
      kp_gap     = 1'b0;
      kp_playing = 1'b1;
    end else if (kp_playing) begin
      if (kp_length == '0) begin
        // empty character ends silently on its first tick
        end_character();
        r.char_done = 1'b1;
      end else begin
        if (!kp_gap) begin
          limit = kp_pattern[kp_index] ? TIMER_W'(kp_unit) * TIMER_W'(3) : TIMER_W'(kp_unit);
          r.tone_on = 1'b1;
          kp_timer  = timer_plus(kp_timer, el);
          if (kp_timer >= limit) begin
            r.tone_on = 1'b0;
            kp_gap    = 1'b1;
            kp_timer  = '0;
          end
        end
        // gap is evaluated in the same tick it opened, so elapsed counts twice
        if (kp_gap) begin
          kp_timer = timer_plus(kp_timer, el);
          if (int'(kp_index) + 1 >= int'(kp_length)) begin
            end_character();
            r.char_done = 1'b1;
          end else if (kp_timer >= TIMER_W'(kp_unit)) begin
            kp_timer = '0;
            kp_gap   = 1'b0;
            kp_index = kp_index + 3'd1;
          end
        end
      end
    end
    r.busy_res = kp_playing;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit and result-side stall pattern
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d results still outstanding", expected_keying.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result sink backpressure: roughly a third of cycles stalled unless on the fast path.
  always @(negedge clk) begin
    out_ch.ready <= fast_path ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result word is matched to the oldest
  // prediction. Sampled on the rising edge, before the block's registers move.
  // ---------------------------------------------------------------------------
  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] ERROR %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    keying_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_keying.size() == 0) begin
        flag_error($sformatf("result word with nothing expected (tone %0b done %0b busy %0b)",
                             out_ch.tone_on, out_ch.char_done, out_ch.busy_res));
      end else begin
        want = expected_keying.pop_front();
        results_checked++;
        if (out_ch.tone_on !== want.tone_on)
          flag_error($sformatf("result %0d tone_on exp %0b got %0b",
                               results_checked, want.tone_on, out_ch.tone_on));
        if (out_ch.char_done !== want.char_done)
          flag_error($sformatf("result %0d char_done exp %0b got %0b",
                               results_checked, want.char_done, out_ch.char_done));
        if (out_ch.busy_res !== want.busy_res)
          flag_error($sformatf("result %0d busy_res exp %0b got %0b",
                               results_checked, want.busy_res, out_ch.busy_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one input word. Valid stays high into the next word unless an idle
  // cycle is rolled, so back-to-back words never toggle valid within a step.
  task automatic send_word(input met_pkg::op_t op, input logic [PATTERN_W-1:0] pat,
                           input logic [LEN_W-1:0] len, input logic [ELAPSED_W-1:0] el);
    @(negedge clk);
    if (!fast_path) begin
      while ($urandom_range(99) < 33) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.pattern     <= pat;
    in_ch.pattern_len <= len;
    in_ch.elapsed     <= el;
    do @(posedge clk); while (!in_ch.ready);
    expected_keying.push_back(advance_keyer(op, pat, len, el));
    words_sent++;
  endtask

  // Stop sending and wait until every result is back, plus an idle margin.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_keying.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the unit length after draining results; the block is not always idle then.
  task automatic write_unit(input logic [UNIT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.unit_ticks <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    kp_unit = value;
    unit_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Elapsed values scaled to the current unit so characters actually progress,
  // with some exact-boundary hits and some full-range values.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int roll;
    int upper;
    roll  = $urandom_range(99);
    upper = 2 * int'(kp_unit) + 1;
    if (upper > 65535) upper = 65535;
    if (roll < 10) return ELAPSED_W'($urandom);
    if (roll < 20) return kp_unit;
    if (roll < 25) return (3 * int'(kp_unit) > 65535) ? 16'hFFFF : ELAPSED_W'(3 * kp_unit);
    return ELAPSED_W'($urandom_range(0, upper));
  endfunction

  // One full character: a start, then ticks until it finishes or 60 ticks are sent,
  // with occasional restarts mid-character and stray ticks while idle.
  task automatic key_one_character();
    int ticks;
    logic [LEN_W-1:0] len;
    len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15)) : LEN_W'($urandom_range(1, 8));
    send_word(met_pkg::OP_START, PATTERN_W'($urandom), len, ELAPSED_W'($urandom));
    ticks = 0;
    while (kp_playing && ticks < 60) begin
      if ($urandom_range(39) == 0)
        send_word(met_pkg::OP_START, PATTERN_W'($urandom), LEN_W'($urandom_range(1, 8)),
                  ELAPSED_W'($urandom));
      else
        send_word(met_pkg::OP_TICK, PATTERN_W'($urandom), LEN_W'($urandom), pick_elapsed());
      ticks++;
    end
    if ($urandom_range(9) == 0)
      send_word(met_pkg::OP_TICK, PATTERN_W'($urandom), LEN_W'($urandom),
                ELAPSED_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset unit of 1200: idle tick, dit then dash, dash finishing on the last tick.
  task automatic test_default_unit();
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'hFFFF);  // not playing: all zero
    send_word(met_pkg::OP_START, 8'h02, 4'd2, 16'd0);     // dit, dash
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'd0);     // tone on, no progress
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'd1200);  // dit ends, gap closes same tick
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'd3599);  // dash one short
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'd1);     // dash ends, last element: done
  endtask

  // All-dash pattern with an oversize length, a restart while playing, and an
  // empty character that ends on its first tick.
  task automatic test_pattern_edges();
    send_word(met_pkg::OP_START, 8'hFF, 4'd15, 16'd0);    // length clamps to eight
    repeat (3) send_word(met_pkg::OP_TICK, 8'h00, 4'd0, 16'hFFFF);
    send_word(met_pkg::OP_START, 8'h00, 4'd0, 16'd0);     // restart with zero length
    send_word(met_pkg::OP_TICK,  8'hFF, 4'hF, 16'd5);
  endtask

  // Smallest, largest and zero unit lengths.
  task automatic test_unit_extremes();
    write_unit(16'd1);
    send_word(met_pkg::OP_START, 8'h55, 4'd1, 16'd0);
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'd0);
    send_word(met_pkg::OP_TICK,  8'h00, 4'd0, 16'd1);
    write_unit(16'hFFFF);
    send_word(met_pkg::OP_START, 8'h01, 4'd1, 16'd0);
    repeat (3) send_word(met_pkg::OP_TICK, 8'h00, 4'd0, 16'hFFFF);
    write_unit(16'd0);                           // every compare passes at once
    send_word(met_pkg::OP_START, 8'hAA, 4'd3, 16'd0);
    repeat (3) send_word(met_pkg::OP_TICK, 8'h00, 4'd0, 16'd0);
  endtask

  // Random characters across a spread of unit lengths, 65535 included.
  task automatic test_random_characters(input int item_budget);
    int phase_end;
    logic [UNIT_W-1:0] unit;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          unit = 16'd1;
        end
        1: begin
          unit = UNIT_W'($urandom_range(2, 16));
        end
        2: begin
          unit = UNIT_W'($urandom_range(17, 300));
        end
        3: begin
          unit = UNIT_W'($urandom_range(301, 4000));
        end
        default: begin
          unit = 16'hFFFF;
        end
      endcase
      write_unit(unit);
      phase_end = words_sent + item_budget / 5;
      while (words_sent < phase_end) key_one_character();
    end
  endtask

  // No idling on either side: words back to back, results drained every cycle.
  task automatic test_back_to_back(input int item_budget);
    int stop_at;
    write_unit(UNIT_W'($urandom_range(2, 8)));
    fast_path = 1'b1;
    stop_at   = words_sent + item_budget;
    while (words_sent < stop_at) key_one_character();
    drain_results();
    fast_path = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = met_pkg::OP_START;
    in_ch.pattern     = '0;
    in_ch.pattern_len = '0;
    in_ch.elapsed     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.unit_ticks = '0;
    out_ch.ready      = 1'b0;
    cycles            = 0;
    words_sent        = 0;
    results_checked   = 0;
    mismatch_count    = 0;
    unit_writes       = 0;
    fast_path         = 1'b0;

    // model comes out of reset with the block
    kp_unit    = met_pkg::UNIT_TICKS_RST;
    kp_playing = 1'b0;
    kp_gap     = 1'b0;
    kp_index   = '0;
    kp_timer   = '0;
    kp_pattern = '0;
    kp_length  = LEN_W'(1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_unit();
    test_pattern_edges();
    test_unit_extremes();
    test_random_characters(ITEM_TARGET - 250);
    test_back_to_back(200);

    drain_results();

    $display("%0d words sent over %0d unit settings, %0d results checked, %0d mismatches",
             words_sent, unit_writes + 1, results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_keying.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
